// ===== rtl/mips_integer_core_step_macros.svh =====
// assertion macros shared by the core modules
`ifndef MIPS_INTEGER_CORE_STEP_MACROS_SVH
`define MIPS_INTEGER_CORE_STEP_MACROS_SVH

// property must hold every cycle outside reset
`define MICS_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// antecedent implies consequent in the next cycle
`define MICS_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

// ===== rtl/mics_pkg.sv =====
// ----------------------------------------------------------------------------
// mics_pkg
// types, codes and helpers shared by the integer core modules
// ----------------------------------------------------------------------------
package mics_pkg;

  localparam logic [31:0] RESET_PC    = 32'hBFC0_0000;
  localparam logic [31:0] TRAP_VECTOR = 32'h8000_0180;
  localparam logic [31:0] IRQ_VECTOR  = 32'h8000_0200;
  localparam logic [31:0] EXC_MASK    = 32'h0000_007C;
  localparam logic [31:0] SEG_MASK    = 32'hF000_0000;
  localparam logic [31:0] JIDX_MASK   = 32'h03FF_FFFF;
  localparam int          QUEUE_DEPTH = 2;

  localparam logic [1:0] OP_EXEC  = 2'd0;
  localparam logic [1:0] OP_LOAD  = 2'd1;
  localparam logic [1:0] OP_IRQ   = 2'd2;
  localparam logic [1:0] OP_CHECK = 2'd3;

  localparam logic [1:0] EXC_NONE    = 2'd0;
  localparam logic [1:0] EXC_SYSCALL = 2'd1;
  localparam logic [1:0] EXC_BREAK   = 2'd2;
  localparam logic [1:0] EXC_IRQ     = 2'd3;

  localparam logic [4:0] CP0_STATUS = 5'd12;
  localparam logic [4:0] CP0_CAUSE  = 5'd13;
  localparam logic [4:0] CP0_EPC    = 5'd14;

  // instruction classes found by the front end
  localparam logic [1:0] CLS_SIMPLE = 2'd0;
  localparam logic [1:0] CLS_MUL    = 2'd1;
  localparam logic [1:0] CLS_DIV    = 2'd2;

  typedef struct packed {
    logic [1:0]  operation;
    logic [31:0] instruction;
    logic [63:0] load_data;
    logic [2:0]  irq_line;
  } in_beat_t;

  typedef struct packed {
    logic [31:0] fetch_pc;
    logic        mem_request;
    logic        mem_write;
    logic [31:0] mem_address;
    logic [1:0]  mem_size;
    logic [63:0] mem_store_data;
    logic        load_waiting;
    logic [1:0]  exception_kind;
  } out_beat_t;

  // queue entry: beat plus the class and divide sign the front end found
  typedef struct packed {
    in_beat_t   beat;
    logic [1:0] cls;
    logic       div_signed;
  } cmd_t;

  function automatic logic [63:0] sx32(input logic [31:0] v);
    return {{32{v[31]}}, v};
  endfunction

  function automatic logic lt_s(input logic [63:0] a, input logic [63:0] b);
    return $signed(a) < $signed(b);
  endfunction

endpackage

// ===== rtl/mics_front.sv =====
// ----------------------------------------------------------------------------
// mics_front
// accepts beats, classifies them and feeds a short queue to the back end
// ----------------------------------------------------------------------------
module mics_front #(
  parameter int Depth = mics_pkg::QUEUE_DEPTH
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_stall,
  input  mics_pkg::in_beat_t in_data,
  output logic              q_valid,
  input  logic              q_pop,
  output mics_pkg::cmd_t    q_data
);
  import mics_pkg::*;

  localparam int AW = (Depth > 1) ? $clog2(Depth) : 1;

  cmd_t              mem [Depth];
  logic [AW-1:0]     wptr;
  logic [AW-1:0]     rptr;
  logic [AW:0]       count;
  cmd_t              cmd_in;
  logic              push;
  logic [5:0]        opc;
  logic [5:0]        fn;

  assign opc = in_data.instruction[31:26];
  assign fn  = in_data.instruction[5:0];

  always_comb begin
    cmd_in            = '0;
    cmd_in.beat       = in_data;
    cmd_in.cls        = CLS_SIMPLE;
    cmd_in.div_signed = 1'b0;
    if (in_data.operation == OP_EXEC && opc == 6'h00) begin
      if (fn == 6'h18 || fn == 6'h19) begin
        cmd_in.cls = CLS_MUL;
      end else if (fn == 6'h1A || fn == 6'h1B) begin
        cmd_in.cls        = CLS_DIV;
        cmd_in.div_signed = (fn == 6'h1A);
      end
    end
  end

  assign in_stall = (count == (AW+1)'(Depth)) ? 1'b1 : 1'b0;
  assign push     = in_valid && !in_stall;
  assign q_valid  = (count != '0);
  assign q_data   = mem[rptr];

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wptr] <= cmd_in;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= '0;
      rptr  <= '0;
      count <= '0;
    end else begin
      if (push) begin
        wptr <= (wptr == AW'(Depth - 1)) ? '0 : wptr + 1'b1;
      end
      if (q_pop) begin
        rptr <= (rptr == AW'(Depth - 1)) ? '0 : rptr + 1'b1;
      end
      count <= count + (AW+1)'(push) - (AW+1)'(q_pop);
    end
  end

  `include "mips_integer_core_step_macros.svh"
  `MICS_ASSERT(a_no_overflow, !(push && count == (AW+1)'(Depth)), "queue overflow")
  `MICS_ASSERT(a_no_underflow, !(q_pop && count == '0), "queue underflow")
  `MICS_ASSERT_NEXT(a_count_push, push && !q_pop, count == $past(count) + 1'b1, "count lost push")

endmodule

// ===== rtl/mics_divider.sv =====
// ----------------------------------------------------------------------------
// mics_divider
// 32-bit restoring divider, one quotient bit a cycle, signed by magnitudes
// ----------------------------------------------------------------------------
module mics_divider (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  input  logic        is_signed,
  input  logic [31:0] dividend,
  input  logic [31:0] divisor,
  output logic        busy,
  output logic        done,
  output logic [31:0] quotient,
  output logic [31:0] remainder
);
  import mics_pkg::*;

  logic [5:0]  step;
  logic [31:0] q;
  logic [32:0] r;
  logic [31:0] d;
  logic        neg_q;
  logic        neg_r;
  logic [32:0] trial;
  logic [31:0] mn;
  logic [31:0] md;

  assign mn    = (is_signed && dividend[31]) ? 32'd0 - dividend : dividend;
  assign md    = (is_signed && divisor[31]) ? 32'd0 - divisor : divisor;
  assign trial = {r[31:0], q[31]} - {1'b0, d};
  assign busy  = (step != 6'd0);
  assign quotient  = neg_q ? 32'd0 - q : q;
  assign remainder = neg_r ? 32'd0 - r[31:0] : r[31:0];

  always_ff @(posedge clk) begin
    if (start) begin
      q     <= mn;
      r     <= '0;
      d     <= md;
      neg_q <= is_signed && (dividend[31] != divisor[31]);
      neg_r <= is_signed && dividend[31];
    end else if (busy) begin
      if (!trial[32]) begin
        r <= trial;
        q <= {q[30:0], 1'b1};
      end else begin
        r <= {r[31:0], q[31]};
        q <= {q[30:0], 1'b0};
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      step <= '0;
      done <= 1'b0;
    end else begin
      done <= (step == 6'd1);
      if (start) begin
        step <= 6'd32;
      end else if (busy) begin
        step <= step - 1'b1;
      end
    end
  end

endmodule

// ===== rtl/mics_back.sv =====
// ----------------------------------------------------------------------------
// mics_back
// architectural state and execution of one queued beat at a time
// ----------------------------------------------------------------------------
module mics_back (
  input  logic               clk,
  input  logic               rst,
  input  logic               q_valid,
  output logic               q_pop,
  input  mics_pkg::cmd_t     q_data,
  output logic               out_valid,
  input  logic               out_stall,
  output mics_pkg::out_beat_t out_data
);
  import mics_pkg::*;

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_MUL  = 2'd1;
  localparam logic [1:0] ST_DIV  = 2'd2;

  logic [63:0] gpr [32];
  logic [31:0] cp0 [32];
  logic [63:0] hi_reg, lo_reg;
  logic [31:0] pc;
  logic        in_delay_slot;
  logic [31:0] delayed_target;
  logic        irq_waiting;
  logic [4:0]  load_dest_reg;
  logic [2:0]  load_kind;
  logic [1:0]  state;
  logic [63:0] product;
  logic        div_start, div_busy, div_done;
  logic [31:0] div_q, div_r;

  // combinational next values for one beat
  logic [63:0] hi_next, lo_next;
  logic [31:0] pc_next;
  logic        ds_next;
  logic [31:0] dt_next;
  logic        irqw_next;
  logic [4:0]  ldr_next;
  logic [2:0]  lk_next;
  logic        gw_en;
  logic [4:0]  gw_idx;
  logic [63:0] gw_val;
  logic        cw_en;
  logic [4:0]  cw_idx;
  logic [31:0] cw_val;
  logic        st_en;
  logic [31:0] st_val;
  logic        ca_en;
  logic [31:0] ca_val;
  logic        epc_en;
  logic [31:0] epc_val;
  out_beat_t   res;
  logic        finish;

  in_beat_t    b;
  logic [5:0]  opc, fn;
  logic [4:0]  rs, rt, rd, sa;
  logic [63:0] vs, vt, simm, uimm;
  logic [31:0] ea, btgt, jtgt, tgt;
  logic        br, done_flag;
  logic [31:0] st, ca;
  logic [7:0]  pend;
  logic        exc_take;
  logic [4:0]  exc_code;
  logic [31:0] exc_vec;
  logic [63:0] ldv;
  logic [63:0] vt_sra;

  mics_divider u_div (
    .clk       (clk),
    .rst       (rst),
    .start     (div_start),
    .is_signed (q_data.div_signed),
    .dividend  (vs[31:0]),
    .divisor   (vt[31:0]),
    .busy      (div_busy),
    .done      (div_done),
    .quotient  (div_q),
    .remainder (div_r)
  );

  assign b    = q_data.beat;
  assign opc  = b.instruction[31:26];
  assign rs   = b.instruction[25:21];
  assign rt   = b.instruction[20:16];
  assign rd   = b.instruction[15:11];
  assign sa   = b.instruction[10:6];
  assign fn   = b.instruction[5:0];
  assign vs   = (rs == 5'd0) ? 64'd0 : gpr[rs];
  assign vt   = (rt == 5'd0) ? 64'd0 : gpr[rt];
  assign simm = {{48{b.instruction[15]}}, b.instruction[15:0]};
  assign uimm = {48'd0, b.instruction[15:0]};
  assign ea   = vs[31:0] + simm[31:0];
  assign btgt = pc + 32'd4 + {simm[29:0], 2'b00};
  assign jtgt = (pc & SEG_MASK) | ((b.instruction & JIDX_MASK) << 2);
  assign st   = cp0[CP0_STATUS];
  assign ca   = cp0[CP0_CAUSE];
  assign pend = ca[15:8] & st[15:8];
  assign vt_sra = sx32(vt[31:0]);

  // start the back end only when the output register can take a beat
  logic can_go;
  assign can_go    = !out_valid || !out_stall;
  assign div_start = (state == ST_IDLE) && q_valid && can_go && q_data.cls == CLS_DIV
                     && vt[31:0] != 32'd0;

  always_comb begin
    case (load_kind)
      3'd1: ldv = {{56{b.load_data[7]}}, b.load_data[7:0]};
      3'd2: ldv = {56'd0, b.load_data[7:0]};
      3'd3: ldv = {{48{b.load_data[15]}}, b.load_data[15:0]};
      3'd4: ldv = {48'd0, b.load_data[15:0]};
      3'd5: ldv = sx32(b.load_data[31:0]);
      3'd6: ldv = {32'd0, b.load_data[31:0]};
      default: ldv = b.load_data;
    endcase
  end

  always_comb begin
    hi_next = hi_reg; lo_next = lo_reg; pc_next = pc;
    ds_next = in_delay_slot; dt_next = delayed_target;
    irqw_next = irq_waiting; ldr_next = load_dest_reg; lk_next = load_kind;
    gw_en = 1'b0; gw_idx = '0; gw_val = '0;
    cw_en = 1'b0; cw_idx = '0; cw_val = '0;
    st_en = 1'b0; st_val = st; ca_en = 1'b0; ca_val = ca;
    epc_en = 1'b0; epc_val = '0;
    res = '0; br = 1'b0; done_flag = 1'b0; tgt = '0;
    exc_take = 1'b0; exc_code = '0; exc_vec = TRAP_VECTOR;
    case (b.operation)
      OP_LOAD: begin
        if (load_kind != 3'd0) begin
          gw_en = 1'b1; gw_idx = load_dest_reg; gw_val = ldv;
        end
        lk_next = '0;
      end
      OP_IRQ: begin
        ca_en = 1'b1;
        ca_val = ca | (32'd1 << (5'd8 + {2'd0, b.irq_line}));
        irqw_next = 1'b1;
      end
      OP_CHECK: begin
        if (irq_waiting && st[0] && !st[1]) begin
          irqw_next = 1'b0;
          if (pend != 8'd0) begin
            exc_take = 1'b1; exc_code = 5'd0; exc_vec = IRQ_VECTOR;
            res.exception_kind = EXC_IRQ;
          end
        end
      end
      default: begin
        case (opc)
          6'h00: begin
            case (fn)
              6'h00: begin gw_en = 1'b1; gw_val = sx32(vt[31:0] << sa); end
              6'h02: begin gw_en = 1'b1; gw_val = sx32(vt[31:0] >> sa); end
              6'h03: begin gw_en = 1'b1; gw_val = sx32(32'($signed(vt_sra) >>> sa)); end
              6'h04: begin gw_en = 1'b1; gw_val = sx32(vt[31:0] << vs[4:0]); end
              6'h06: begin gw_en = 1'b1; gw_val = sx32(vt[31:0] >> vs[4:0]); end
              6'h07: begin
                gw_en = 1'b1; gw_val = sx32(32'($signed(vt_sra) >>> vs[4:0]));
              end
              6'h08: begin br = 1'b1; tgt = vs[31:0]; end
              6'h09: begin
                br = 1'b1; tgt = vs[31:0]; gw_en = 1'b1; gw_val = sx32(pc + 32'd8);
              end
              6'h0A: begin gw_en = (vt == 64'd0); gw_val = vs; end
              6'h0B: begin gw_en = (vt != 64'd0); gw_val = vs; end
              6'h0C: begin
                exc_take = 1'b1; exc_code = 5'd8; done_flag = 1'b1;
                res.exception_kind = EXC_SYSCALL;
              end
              6'h0D: begin
                exc_take = 1'b1; exc_code = 5'd9; done_flag = 1'b1;
                res.exception_kind = EXC_BREAK;
              end
              6'h10: begin gw_en = 1'b1; gw_val = hi_reg; end
              6'h11: hi_next = vs;
              6'h12: begin gw_en = 1'b1; gw_val = lo_reg; end
              6'h13: lo_next = vs;
              6'h18, 6'h19: begin
                lo_next = sx32(product[31:0]); hi_next = sx32(product[63:32]);
                gw_en = 1'b1; gw_val = sx32(product[31:0]);
              end
              6'h1A, 6'h1B: begin
                if (vt[31:0] != 32'd0) begin
                  lo_next = sx32(div_q); hi_next = sx32(div_r);
                end
              end
              6'h20, 6'h21: begin gw_en = 1'b1; gw_val = sx32(vs[31:0] + vt[31:0]); end
              6'h22, 6'h23: begin gw_en = 1'b1; gw_val = sx32(vs[31:0] - vt[31:0]); end
              6'h24: begin gw_en = 1'b1; gw_val = vs & vt; end
              6'h25: begin gw_en = 1'b1; gw_val = vs | vt; end
              6'h26: begin gw_en = 1'b1; gw_val = vs ^ vt; end
              6'h27: begin gw_en = 1'b1; gw_val = ~(vs | vt); end
              6'h2A: begin gw_en = 1'b1; gw_val = {63'd0, lt_s(vs, vt)}; end
              6'h2B: begin gw_en = 1'b1; gw_val = {63'd0, vs < vt}; end
              6'h2C, 6'h2D: begin gw_en = 1'b1; gw_val = vs + vt; end
              6'h2E, 6'h2F: begin gw_en = 1'b1; gw_val = vs - vt; end
              6'h38: begin gw_en = 1'b1; gw_val = vt << sa; end
              6'h3A: begin gw_en = 1'b1; gw_val = vt >> sa; end
              6'h3B: begin gw_en = 1'b1; gw_val = 64'($signed(vt) >>> sa); end
              6'h3C: begin gw_en = 1'b1; gw_val = vt << ({1'b1, sa}); end
              6'h3E: begin gw_en = 1'b1; gw_val = vt >> ({1'b1, sa}); end
              6'h3F: begin gw_en = 1'b1; gw_val = 64'($signed(vt) >>> {1'b1, sa}); end
              default: ;
            endcase
            gw_idx = rd;
          end
          6'h01: begin
            tgt = btgt;
            if (rt == 5'h00 || rt == 5'h10) br = lt_s(vs, 64'd0);
            else if (rt == 5'h01 || rt == 5'h11) br = !lt_s(vs, 64'd0);
            if (rt == 5'h10 || rt == 5'h11) begin
              gw_en = 1'b1; gw_idx = 5'd31; gw_val = sx32(pc + 32'd8);
            end
          end
          6'h02: begin br = 1'b1; tgt = jtgt; end
          6'h03: begin
            br = 1'b1; tgt = jtgt; gw_en = 1'b1; gw_idx = 5'd31; gw_val = sx32(pc + 32'd8);
          end
          6'h04: begin br = (vs == vt); tgt = btgt; end
          6'h05: begin br = (vs != vt); tgt = btgt; end
          6'h06: begin br = lt_s(vs, 64'd1); tgt = btgt; end
          6'h07: begin br = !lt_s(vs, 64'd1); tgt = btgt; end
          6'h08, 6'h09: begin gw_en = 1'b1; gw_idx = rt; gw_val = sx32(vs[31:0] + simm[31:0]); end
          6'h0A: begin gw_en = 1'b1; gw_idx = rt; gw_val = {63'd0, lt_s(vs, simm)}; end
          6'h0B: begin gw_en = 1'b1; gw_idx = rt; gw_val = {63'd0, vs < simm}; end
          6'h0C: begin gw_en = 1'b1; gw_idx = rt; gw_val = vs & uimm; end
          6'h0D: begin gw_en = 1'b1; gw_idx = rt; gw_val = vs | uimm; end
          6'h0E: begin gw_en = 1'b1; gw_idx = rt; gw_val = vs ^ uimm; end
          6'h0F: begin gw_en = 1'b1; gw_idx = rt; gw_val = sx32({b.instruction[15:0], 16'd0}); end
          6'h10: begin
            if (rs == 5'h00) begin
              gw_en = 1'b1; gw_idx = rt; gw_val = sx32(cp0[rd]);
            end else if (rs == 5'h04) begin
              cw_en = 1'b1; cw_idx = rd; cw_val = vt[31:0];
            end else if (rs == 5'h10 && fn == 6'h18) begin
              st_en = 1'b1; st_val = st & ~32'd2;
              pc_next = cp0[CP0_EPC]; ds_next = 1'b0; done_flag = 1'b1;
            end
          end
          6'h20, 6'h24, 6'h21, 6'h25, 6'h23, 6'h27, 6'h37: begin
            res.mem_request = 1'b1; res.mem_address = ea; ldr_next = rt;
            case (opc)
              6'h20: begin lk_next = 3'd1; res.mem_size = 2'd0; end
              6'h24: begin lk_next = 3'd2; res.mem_size = 2'd0; end
              6'h21: begin lk_next = 3'd3; res.mem_size = 2'd1; end
              6'h25: begin lk_next = 3'd4; res.mem_size = 2'd1; end
              6'h23: begin lk_next = 3'd5; res.mem_size = 2'd2; end
              6'h27: begin lk_next = 3'd6; res.mem_size = 2'd2; end
              default: begin lk_next = 3'd7; res.mem_size = 2'd3; end
            endcase
          end
          6'h28, 6'h29, 6'h2B, 6'h3F: begin
            res.mem_request = 1'b1; res.mem_write = 1'b1; res.mem_address = ea;
            case (opc)
              6'h28: begin res.mem_size = 2'd0; res.mem_store_data = {56'd0, vt[7:0]}; end
              6'h29: begin res.mem_size = 2'd1; res.mem_store_data = {48'd0, vt[15:0]}; end
              6'h2B: begin res.mem_size = 2'd2; res.mem_store_data = {32'd0, vt[31:0]}; end
              default: begin res.mem_size = 2'd3; res.mem_store_data = vt; end
            endcase
          end
          default: ;
        endcase
        if (!done_flag) begin
          if (in_delay_slot) begin
            pc_next = delayed_target; ds_next = 1'b0;
          end else if (br) begin
            ds_next = 1'b1; dt_next = tgt; pc_next = pc + 32'd4;
          end else begin
            pc_next = pc + 32'd4;
          end
        end
      end
    endcase
    if (exc_take) begin
      if (!st[1]) begin
        epc_en  = 1'b1;
        epc_val = in_delay_slot ? pc - 32'd4 : pc;
        ca_val  = in_delay_slot ? (ca | 32'h8000_0000) : (ca & ~32'h8000_0000);
      end
      ca_en  = 1'b1;
      ca_val = (ca_val & ~EXC_MASK) | {25'd0, exc_code, 2'b00};
      st_en  = 1'b1; st_val = st | 32'd2;
      pc_next = exc_vec; ds_next = 1'b0;
    end
    res.fetch_pc     = pc_next;
    res.load_waiting = (lk_next != 3'd0);
  end

  // simple beats finish at once; multiplies wait for the product
  // register, divides for the divider (zero divisor finishes at once)
  always_comb begin
    finish = 1'b0;
    if (q_valid && can_go) begin
      case (state)
        ST_IDLE: finish = (q_data.cls == CLS_SIMPLE) ||
                          (q_data.cls == CLS_DIV && vt[31:0] == 32'd0);
        ST_MUL:  finish = 1'b1;
        ST_DIV:  finish = div_done;
        default: finish = 1'b0;
      endcase
    end
  end
  assign q_pop = finish;

  always_ff @(posedge clk) begin
    if (fn == 6'h18) product <= 64'($signed(vs[31:0]) * $signed(vt[31:0]));
    else             product <= {32'd0, vs[31:0]} * {32'd0, vt[31:0]};
  end

  always_ff @(posedge clk) begin
    if (finish) begin
      out_data <= res;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < 32; i++) begin
        gpr[i] <= '0;
        cp0[i] <= '0;
      end
      hi_reg <= '0; lo_reg <= '0; pc <= RESET_PC;
      in_delay_slot <= 1'b0; delayed_target <= '0; irq_waiting <= 1'b0;
      load_dest_reg <= '0; load_kind <= '0; state <= ST_IDLE; out_valid <= 1'b0;
    end else begin
      if (out_valid && !out_stall) out_valid <= 1'b0;
      if (finish) begin
        out_valid <= 1'b1;
        state <= ST_IDLE;
        hi_reg <= hi_next; lo_reg <= lo_next; pc <= pc_next;
        in_delay_slot <= ds_next; delayed_target <= dt_next;
        irq_waiting <= irqw_next; load_dest_reg <= ldr_next; load_kind <= lk_next;
        if (gw_en && gw_idx != 5'd0) gpr[gw_idx] <= gw_val;
        if (cw_en) cp0[cw_idx] <= cw_val;
        if (st_en) cp0[CP0_STATUS] <= st_val;
        if (ca_en) cp0[CP0_CAUSE] <= ca_val;
        if (epc_en) cp0[CP0_EPC] <= epc_val;
      end else if (state == ST_IDLE && q_valid && can_go) begin
        if (q_data.cls == CLS_MUL) state <= ST_MUL;
        else if (q_data.cls == CLS_DIV) state <= ST_DIV;
      end
    end
  end

  `include "mips_integer_core_step_macros.svh"
  `MICS_ASSERT(a_gpr0_zero, gpr[0] == 64'd0, "register zero written")
  `MICS_ASSERT(a_pop_room, !(q_pop && out_valid && out_stall), "pop into stalled output")
  `MICS_ASSERT_NEXT(a_pop_shows, q_pop, out_valid, "finished beat not shown")

endmodule

// ===== rtl/mips_integer_core_step.sv =====
// ----------------------------------------------------------------------------
// mips_integer_core_step
// integer core: a front end queues and classifies beats, a back end executes
// ----------------------------------------------------------------------------
// channel  | direction | handshake          | payload
// in       | input     | in_valid/in_stall  | mics_pkg::in_beat_t
// out      | output    | out_valid/out_stall| mics_pkg::out_beat_t
//
// a beat is written into the queue and then executed by the back end;
// multiplies also pass through the product register, and divides wait
// for the bit-serial divider
// one result beat per input beat, held in an output register while stalled
// reset (rst, synchronous) empties the queue and loads the reset pc
module mips_integer_core_step #(
  parameter int QueueDepth = mics_pkg::QUEUE_DEPTH
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_stall,
  input  mics_pkg::in_beat_t  in_data,
  output logic                out_valid,
  input  logic                out_stall,
  output mics_pkg::out_beat_t out_data
);
  import mics_pkg::*;

  logic q_valid;
  logic q_pop;
  cmd_t q_data;

  // front end: classification and decoupling queue
  mics_front #(.Depth(QueueDepth)) u_front (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_data  (in_data),
    .q_valid  (q_valid),
    .q_pop    (q_pop),
    .q_data   (q_data)
  );

  // back end: state, execution, result register
  mics_back u_back (
    .clk       (clk),
    .rst       (rst),
    .q_valid   (q_valid),
    .q_pop     (q_pop),
    .q_data    (q_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

endmodule
